// File: hw/rtl/trst_pkg.sv
// ----------------------------------------------------------------------------
// TCP receive sequence tracker package
// Request and result types, register indexes and protocol constants.
// ----------------------------------------------------------------------------
package trst_pkg;

	// Register indexes on the configuration port
	localparam logic [1:0] REG_PEER_IP      = 2'd0;
	localparam logic [1:0] REG_PEER_PORT    = 2'd1;
	localparam logic [1:0] REG_LOCAL_PORT   = 2'd2;
	localparam logic [1:0] REG_BUFFER_LIMIT = 2'd3;

	// Register reset values
	localparam logic [15:0] LOCAL_PORT_RST   = 16'd49152;
	localparam logic [11:0] BUFFER_LIMIT_RST = 12'd1460;

	// Protocol constants
	localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
	localparam logic [7:0]  PROTO_TCP     = 8'd6;
	localparam int unsigned FLAG_FIN_BIT  = 0;
	localparam int unsigned FLAG_SYN_BIT  = 1;
	localparam logic [10:0] MIN_FRAME_LEN = 11'd54;
	localparam logic [11:0] LIMIT_MAX     = 12'd2048;
	localparam logic [6:0]  HDR_BASE      = 7'd34;
	localparam logic [15:0] IP_HDR_LEN    = 16'd20;

	// Result status codes
	localparam logic [2:0] ST_IGNORED    = 3'd0;
	localparam logic [2:0] ST_OUT_OF_ORD = 3'd1;
	localparam logic [2:0] ST_SYN        = 3'd2;
	localparam logic [2:0] ST_DATA       = 3'd3;
	localparam logic [2:0] ST_NO_DATA    = 3'd4;

	typedef struct packed {
		logic [10:0] frame_len;
		logic [15:0] ether_type;
		logic [7:0]  ip_proto;
		logic [31:0] ip_source;
		logic [15:0] ip_total_len;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [3:0]  header_words;
		logic [31:0] seq_num;
		logic [7:0]  flag_bits;
	} frame_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  seen_flags;
		logic [11:0] payload_len;
		logic [6:0]  payload_offset;
		logic [31:0] ack_value;
	} result_t;

endpackage

// File: hw/rtl/tcp_receive_sequence_tracker.sv
// ----------------------------------------------------------------------------
// TCP receive sequence tracker
// Filters parsed frame headers for one TCP connection and tracks the
// expected receive sequence number, one result per frame header.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                 Payload
//  frame     in         frame_valid/frame_ready   trst_pkg::frame_t
//  result    out        result_valid/result_ready trst_pkg::result_t
//  cfg       in         cfg_valid/cfg_ready       cfg_index, cfg_data
//
// One request per cycle unless the result stalls: a request is captured in
// stage 1, evaluated there, and its result is registered and offered from the
// result register. The sequence compare and the 32-bit add set that rate.
// A stalled result lets stage 1 take one more request; ready then falls.
// Reset clears the valid bits and the expected sequence number and loads
// the configuration registers with their reset values.
//
module tcp_receive_sequence_tracker (
	input  logic                clk,
	input  logic                arst_n,
	// frame header requests
	input  logic                frame_valid,
	output logic                frame_ready,
	input  trst_pkg::frame_t    frame,
	// results
	output logic                result_valid,
	input  logic                result_ready,
	output trst_pkg::result_t   result,
	// configuration writes
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [31:0]         cfg_data
);

	// Configuration registers
	logic [31:0] peer_ip_q;
	logic [15:0] peer_port_q;
	logic [15:0] local_port_q;
	logic [11:0] buffer_limit_q;

	// Connection state
	logic [31:0] expected_seq_q;

	// Pipeline registers
	logic               valid_s1;
	trst_pkg::frame_t   frame_s1;
	logic               valid_s2;
	trst_pkg::result_t  result_s2;

	// Stage 1 evaluation
	logic               advance_s2;
	logic               match;
	logic [5:0]         hdr_bytes;
	logic [15:0]        data_len_raw;
	logic [11:0]        limit;
	logic [11:0]        data_len;
	logic               is_syn;
	logic               is_fin;
	logic               in_order;
	logic [31:0]        seq_plus_data;
	logic [31:0]        seq_plus_one;
	logic [31:0]        next_seq;
	trst_pkg::result_t  result_d;

	// Configuration writes are accepted at any time; the user writes only
	// while the block is idle.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peer_ip_q      <= '0;
			peer_port_q    <= '0;
			local_port_q   <= trst_pkg::LOCAL_PORT_RST;
			buffer_limit_q <= trst_pkg::BUFFER_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				trst_pkg::REG_PEER_IP:      peer_ip_q      <= cfg_data;
				trst_pkg::REG_PEER_PORT:    peer_port_q    <= cfg_data[15:0];
				trst_pkg::REG_LOCAL_PORT:   local_port_q   <= cfg_data[15:0];
				trst_pkg::REG_BUFFER_LIMIT: buffer_limit_q <= cfg_data[11:0];
				default: begin
				end
			endcase
		end
	end

	// The result register loads whenever it is empty or being drained; the
	// input register loads whenever it is empty or moving on.
	assign advance_s2  = valid_s1 && (!valid_s2 || result_ready);
	assign frame_ready = !valid_s1 || advance_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frame_ready) begin
			valid_s1 <= frame_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (frame_ready && frame_valid) begin
			frame_s1 <= frame;
		end
	end

	// Frame filter: long enough, IPv4, TCP, and the configured connection.
	assign match = (frame_s1.frame_len >= trst_pkg::MIN_FRAME_LEN)
		&& (frame_s1.ether_type == trst_pkg::ETH_TYPE_IPV4)
		&& (frame_s1.ip_proto == trst_pkg::PROTO_TCP)
		&& (frame_s1.ip_source == peer_ip_q)
		&& (frame_s1.dst_port == local_port_q)
		&& (frame_s1.src_port == peer_port_q);

	// Payload length wraps in 16 bits, so a short data offset or a bogus
	// total length gives a large value that the clamp then limits.
	assign hdr_bytes    = {frame_s1.header_words, 2'b00};
	assign data_len_raw = frame_s1.ip_total_len - trst_pkg::IP_HDR_LEN
		- {10'd0, hdr_bytes};
	assign limit        = (buffer_limit_q > trst_pkg::LIMIT_MAX) ?
		trst_pkg::LIMIT_MAX : buffer_limit_q;
	assign data_len     = (data_len_raw > {4'd0, limit}) ? limit : data_len_raw[11:0];

	assign is_syn   = frame_s1.flag_bits[trst_pkg::FLAG_SYN_BIT];
	assign is_fin   = frame_s1.flag_bits[trst_pkg::FLAG_FIN_BIT];
	assign in_order = (frame_s1.seq_num == expected_seq_q);

	// An in-order segment starts at the expected sequence, so seq plus
	// length plus FIN covers both the data case and the bare FIN case.
	assign seq_plus_data = frame_s1.seq_num + {20'd0, data_len} + {31'd0, is_fin};
	assign seq_plus_one  = frame_s1.seq_num + 32'd1;

	always_comb begin
		next_seq                = expected_seq_q;
		result_d.status         = trst_pkg::ST_IGNORED;
		result_d.seen_flags     = '0;
		result_d.payload_len    = '0;
		result_d.payload_offset = trst_pkg::HDR_BASE;
		if (match) begin
			result_d.seen_flags     = frame_s1.flag_bits;
			result_d.payload_offset = trst_pkg::HDR_BASE + {1'b0, hdr_bytes};
			if (is_syn) begin
				// SYN wins over data and FIN and restarts the sequence.
				next_seq        = seq_plus_one;
				result_d.status = trst_pkg::ST_SYN;
			end else if (data_len != 12'd0) begin
				if (!in_order) begin
					result_d.status = trst_pkg::ST_OUT_OF_ORD;
				end else begin
					next_seq             = seq_plus_data;
					result_d.status      = trst_pkg::ST_DATA;
					result_d.payload_len = data_len;
				end
			end else begin
				if (is_fin && in_order) begin
					next_seq = seq_plus_data;
				end
				result_d.status = trst_pkg::ST_NO_DATA;
			end
		end
		result_d.ack_value = next_seq;
	end

	// The state moves exactly when the request leaves stage 1.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_seq_q <= '0;
		end else if (advance_s2) begin
			expected_seq_q <= next_seq;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || result_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s2) begin
			result_s2 <= result_d;
		end
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

`ifndef NO_ASSERTIONS
	// An ignored frame reports no flags, no payload and the base offset.
	a_ignored_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.status == trst_pkg::ST_IGNORED) |->
		(result.seen_flags == 8'd0 && result.payload_len == 12'd0
			&& result.payload_offset == trst_pkg::HDR_BASE))
		else $error("ignored frame carries header data");

	// Payload bytes are reported only for accepted data.
	a_len_only_data: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.payload_len != 12'd0) |->
		(result.status == trst_pkg::ST_DATA))
		else $error("payload length without accepted data");

	// A stalled stage 1 keeps its request and the connection state.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance_s2) |=>
		(valid_s1 && $stable(frame_s1) && $stable(expected_seq_q)))
		else $error("stage 1 lost its request or state moved while stalled");

	// The reported acknowledgement is the state after that request.
	a_ack_is_state: assert property (@(posedge clk) disable iff (!arst_n)
		advance_s2 |=> (result.ack_value == expected_seq_q))
		else $error("ack value differs from the expected sequence");

	// An empty result register never blocks the input.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> frame_ready)
		else $error("input blocked with an empty result register");
`endif

endmodule

// File: test/tcp_receive_sequence_tracker_tb.sv
// ----------------------------------------------------------------------------
// TCP receive sequence tracker testbench
// Sends parsed frame headers through the tracker under several connection
// settings and checks every result against a predicted acknowledgement
// state. Both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module tcp_receive_sequence_tracker_tb;
	import trst_pkg::*;

	// TCP flag bytes used to build segments.
	localparam logic [7:0] FL_FIN = 8'h01;
	localparam logic [7:0] FL_SYN = 8'h02;
	localparam logic [7:0] FL_PSH = 8'h08;
	localparam logic [7:0] FL_ACK = 8'h10;

	// The run is cut off here as a failure.
	localparam int CYCLE_LIMIT = 200000;

	// Each setting gets this many random requests.
	localparam int PHASE_ITEMS = 140;

	// The receiver holds off this long when asked to, so the block fills up.
	localparam int HOLD_CYCLES = 80;

	// Scoreboard. It keeps its own copy of the connection registers and of
	// the expected sequence number, works out the result of each accepted
	// request and compares the results of the block against that in order.
	class ack_scoreboard;
		logic [31:0] peer_ip;
		logic [15:0] peer_port;
		logic [15:0] local_port;
		logic [11:0] buffer_limit;
		logic [31:0] next_seq;
		result_t     pending_acks[$];
		int          mismatches;

		function new();
			peer_ip      = '0;
			peer_port    = '0;
			local_port   = LOCAL_PORT_RST;
			buffer_limit = BUFFER_LIMIT_RST;
			next_seq     = '0;
			mismatches   = 0;
		endfunction

		function void reg_written(logic [1:0] index, logic [31:0] data);
			case (index)
				REG_PEER_IP: begin
					peer_ip = data;
				end
				REG_PEER_PORT: begin
					peer_port = data[15:0];
				end
				REG_LOCAL_PORT: begin
					local_port = data[15:0];
				end
				REG_BUFFER_LIMIT: begin
					buffer_limit = data[11:0];
				end
				default: begin
				end
			endcase
		endfunction

		function void frame_accepted(frame_t f);
			result_t     r;
			logic [15:0] hdr_bytes;
			logic [15:0] data_len;
			logic [11:0] clamp;
			bit          hit;

			r = '0;
			r.status = ST_IGNORED;
			r.payload_offset = HDR_BASE;
			hit = f.frame_len >= MIN_FRAME_LEN && f.ether_type == ETH_TYPE_IPV4 &&
				f.ip_proto == PROTO_TCP && f.ip_source == peer_ip &&
				f.dst_port == local_port && f.src_port == peer_port;
			if (hit) begin
				hdr_bytes = {10'd0, f.header_words, 2'b00};
				clamp = (buffer_limit > LIMIT_MAX) ? LIMIT_MAX : buffer_limit;
				// The length wraps at 16 bits before the clamp is applied.
				data_len = f.ip_total_len - IP_HDR_LEN - hdr_bytes;
				if (data_len > {4'd0, clamp}) begin
					data_len = {4'd0, clamp};
				end
				r.seen_flags = f.flag_bits;
				r.payload_offset = HDR_BASE + {1'b0, f.header_words, 2'b00};
				if (f.flag_bits[FLAG_SYN_BIT]) begin
					next_seq = f.seq_num + 32'd1;
					r.status = ST_SYN;
				end else if (data_len != 16'd0) begin
					if (f.seq_num != next_seq) begin
						r.status = ST_OUT_OF_ORD;
					end else begin
						next_seq = f.seq_num + {16'd0, data_len} +
							{31'd0, f.flag_bits[FLAG_FIN_BIT]};
						r.status = ST_DATA;
						r.payload_len = data_len[11:0];
					end
				end else begin
					if (f.flag_bits[FLAG_FIN_BIT] && f.seq_num == next_seq) begin
						next_seq = next_seq + 32'd1;
					end
					r.status = ST_NO_DATA;
				end
			end
			r.ack_value = next_seq;
			pending_acks.push_back(r);
		endfunction

		function void compare(string field, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
				mismatches++;
			end
		endfunction

		function void result_seen(result_t r);
			result_t want;

			if (pending_acks.size() == 0) begin
				$display("%0t: result with no request outstanding, expected none, actual %h",
					$time, r);
				mismatches++;
			end else begin
				want = pending_acks.pop_front();
				compare("status", 32'(want.status), 32'(r.status));
				compare("seen_flags", 32'(want.seen_flags), 32'(r.seen_flags));
				compare("payload_len", 32'(want.payload_len), 32'(r.payload_len));
				compare("payload_offset", 32'(want.payload_offset), 32'(r.payload_offset));
				compare("ack_value", want.ack_value, r.ack_value);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        frame_valid;
	logic        frame_ready;
	frame_t      frame;
	logic        result_valid;
	logic        result_ready;
	result_t     result;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	ack_scoreboard sb = new();

	// When steady is set neither side idles. When hold_results is set the
	// receiver keeps ready low through a hold and then clears the flag.
	bit steady;
	bit hold_results;
	int cycle_count;

	tcp_receive_sequence_tracker dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.frame_valid  (frame_valid),
		.frame_ready  (frame_ready),
		.frame        (frame),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever begin
			#5 clk = ~clk;
		end
	end

	// Watchdog. A run that hangs on a handshake or never gets all of its
	// results back ends here as a failure.
	initial begin
		cycle_count = 0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Receiver. Ready changes only at the falling edge. Outside of a hold
	// it stalls at random about 12 percent of the time, unless the run is steady.
	initial begin
		result_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_results) begin
				result_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_results = 1'b0;
			end else begin
				result_ready <= steady || ($urandom_range(99) >= 12);
			end
		end
	end

	// Results are sampled at the rising edge, where both sides of the
	// handshake have settled.
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			sb.result_seen(result);
		end
	end

	// Offers one frame header and returns at the edge where it is taken.
	// Valid is left high so that the next request can follow at once; an
	// idle gap lowers it at a falling edge of its own first.
	task automatic send_frame(frame_t f);
		if (!steady && $urandom_range(99) < 12) begin
			@(negedge clk);
			frame_valid <= 1'b0;
			repeat ($urandom_range(3)) @(negedge clk);
		end
		@(negedge clk);
		frame_valid <= 1'b1;
		frame <= f;
		do begin
			@(posedge clk);
		end while (!frame_ready);
		sb.frame_accepted(f);
	endtask

	task automatic write_reg(logic [1:0] index, logic [31:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		sb.reg_written(index, data);
	endtask

	// Writes all four connection registers back to back. It is only called
	// while no request is in the block.
	task automatic configure(logic [31:0] ip, logic [15:0] pport, logic [15:0] lport,
		logic [11:0] clamp);
		write_reg(REG_PEER_IP, ip);
		write_reg(REG_PEER_PORT, {16'd0, pport});
		write_reg(REG_LOCAL_PORT, {16'd0, lport});
		write_reg(REG_BUFFER_LIMIT, {20'd0, clamp});
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Stops offering and waits until every expected result has come back.
	task automatic drain();
		@(negedge clk);
		frame_valid <= 1'b0;
		while (sb.pending_acks.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	// Builds a segment of the configured connection. The IP total length is
	// chosen so that the payload is dlen bytes before the clamp.
	function automatic frame_t seg(logic [31:0] seq, logic [3:0] hw, logic [15:0] dlen,
		logic [7:0] flags);
		frame_t f;

		f.frame_len    = 11'($urandom_range(1514, 54));
		f.ether_type   = ETH_TYPE_IPV4;
		f.ip_proto     = PROTO_TCP;
		f.ip_source    = sb.peer_ip;
		f.ip_total_len = IP_HDR_LEN + {10'd0, hw, 2'b00} + dlen;
		f.src_port     = sb.peer_port;
		f.dst_port     = sb.local_port;
		f.header_words = hw;
		f.seq_num      = seq;
		f.flag_bits    = flags;
		return f;
	endfunction

	// Random request. Most are segments of the connection that the tracker
	// acts on, the bulk of them in order so that the expected sequence
	// keeps moving; the rest are near misses and pure noise.
	function automatic frame_t random_frame();
		frame_t      f;
		int unsigned pick;
		logic [3:0]  hw;
		logic [15:0] dlen;
		logic [7:0]  flags;
		logic [31:0] seq;

		pick = $urandom_range(99);
		hw = ($urandom_range(9) == 0) ? 4'($urandom_range(4)) : 4'($urandom_range(15, 5));
		case ($urandom_range(3))
			0: begin
				dlen = 16'd0;
			end
			1, 2: begin
				dlen = 16'($urandom_range(64, 1));
			end
			default: begin
				dlen = 16'($urandom_range(sb.buffer_limit + 40));
			end
		endcase
		flags = 8'($urandom);
		flags[FLAG_SYN_BIT] = 1'b0;
		seq = sb.next_seq;

		if (pick < 60) begin
			f = seg(seq, hw, dlen, flags);
		end else if (pick < 72) begin
			// Ahead of or behind the expected sequence.
			seq = ($urandom_range(1)) ? seq + $urandom_range(5000, 1) : $urandom;
			f = seg(seq, hw, dlen, flags);
		end else if (pick < 80) begin
			// A new connection, sometimes right below the wrap point.
			flags[FLAG_SYN_BIT] = 1'b1;
			seq = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF - $urandom_range(3000) : $urandom;
			f = seg(seq, hw, dlen, flags);
		end else if (pick < 86) begin
			// Any total length at all, so the length often wraps and clamps.
			f = seg(seq, hw, dlen, flags);
			f.ip_total_len = 16'($urandom);
		end else begin
			f = seg(seq, hw, dlen, 8'($urandom));
			case ($urandom_range(6))
				0: begin
					f.frame_len = 11'($urandom_range(53));
				end
				1: begin
					f.ether_type = 16'($urandom);
				end
				2: begin
					f.ip_proto = 8'($urandom);
				end
				3: begin
					f.ip_source = f.ip_source ^ (32'd1 << $urandom_range(31));
				end
				4: begin
					f.src_port = f.src_port ^ (16'd1 << $urandom_range(15));
				end
				5: begin
					f.dst_port = f.dst_port ^ (16'd1 << $urandom_range(15));
				end
				default: begin
					f.frame_len    = 11'($urandom_range(1514));
					f.ether_type   = 16'($urandom);
					f.ip_proto     = 8'($urandom);
					f.ip_source    = $urandom;
					f.ip_total_len = 16'($urandom);
					f.src_port     = 16'($urandom);
					f.dst_port     = 16'($urandom);
					f.header_words = 4'($urandom);
					f.seq_num      = $urandom;
				end
			endcase
		end
		return f;
	endfunction

	// Hand-picked requests under the reset settings: every way a frame can
	// miss the connection, every status, the sequence wrap, the length wrap
	// and the clamp, a short data offset and SYN winning over data and FIN.
	task automatic run_directed();
		frame_t f;

		// One byte short of the smallest TCP frame.
		f = seg(sb.next_seq, 4'd5, 16'd10, FL_ACK | FL_PSH);
		f.frame_len = MIN_FRAME_LEN - 11'd1;
		send_frame(f);
		// SYN at the top of the sequence space makes the next value zero.
		f = seg(32'hFFFF_FFFF, 4'd5, 16'd0, FL_SYN);
		f.frame_len = MIN_FRAME_LEN;
		send_frame(f);
		send_frame(seg(sb.next_seq, 4'd5, 16'd100, FL_ACK | FL_PSH));
		f = seg(sb.next_seq, 4'd5, 16'd8, FL_ACK);
		f.ether_type = 16'h86DD;
		send_frame(f);
		f = seg(sb.next_seq, 4'd5, 16'd8, FL_ACK);
		f.ip_proto = 8'd17;
		send_frame(f);
		f = seg(sb.next_seq, 4'd5, 16'd8, FL_ACK);
		f.ip_source = ~sb.peer_ip;
		send_frame(f);
		f = seg(sb.next_seq, 4'd5, 16'd8, FL_ACK);
		f.src_port = sb.peer_port + 16'd1;
		send_frame(f);
		f = seg(sb.next_seq, 4'd5, 16'd8, FL_ACK);
		f.dst_port = ~sb.local_port;
		send_frame(f);
		// Data that skips ahead of the expected sequence.
		send_frame(seg(sb.next_seq + 32'd1000, 4'd5, 16'd50, FL_ACK));
		// A bare ACK, then an in-order FIN, then a stale FIN.
		send_frame(seg(sb.next_seq, 4'd8, 16'd0, FL_ACK));
		send_frame(seg(sb.next_seq, 4'd5, 16'd0, FL_ACK | FL_FIN));
		send_frame(seg(sb.next_seq - 32'd5, 4'd5, 16'd0, FL_FIN));
		send_frame(seg(sb.next_seq, 4'd6, 16'd300, FL_ACK | FL_PSH | FL_FIN));
		// A data offset below the legal minimum is taken as it is.
		send_frame(seg(sb.next_seq, 4'd0, 16'd40, FL_ACK));
		f = seg(sb.next_seq, 4'd15, 16'd1400, FL_ACK);
		f.frame_len = 11'd1514;
		send_frame(f);
		// Total lengths below and far above the headers both end at the clamp.
		f = seg(sb.next_seq, 4'd5, 16'd0, FL_ACK);
		f.ip_total_len = 16'd0;
		send_frame(f);
		f = seg(sb.next_seq, 4'd15, 16'd0, FL_ACK);
		f.ip_total_len = 16'hFFFF;
		send_frame(f);
		send_frame(seg(sb.next_seq, 4'd5, {4'd0, BUFFER_LIMIT_RST}, FL_ACK));
		send_frame(seg(sb.next_seq, 4'd5, {4'd0, BUFFER_LIMIT_RST} + 16'd1, FL_ACK));
		// All flags set: SYN wins, the payload and FIN are not counted.
		send_frame(seg(32'h1234_5678, 4'd5, 16'd200, 8'hFF));
		send_frame(seg(32'hFFFF_FF00, 4'd5, 16'd0, FL_SYN));
		// This segment carries the sequence across zero.
		send_frame(seg(sb.next_seq, 4'd5, 16'd512, 8'h00));
	endtask

	initial begin
		arst_n = 1'b0;
		frame_valid = 1'b0;
		frame = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_PEER_IP;
		cfg_data = '0;
		steady = 1'b0;
		hold_results = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		run_directed();
		drain();

		for (int phase = 0; phase < 6; phase++) begin
			// Each phase starts from an idle block with a new setting: the
			// all-ones and all-zero extremes, a zero and a one-byte clamp, a random
			// clamp, a small clamp and the reset clamp.
			case (phase)
				0: begin
					configure(32'hFFFF_FFFF, 16'hFFFF, 16'h0000, LIMIT_MAX);
				end
				1: begin
					configure($urandom, 16'($urandom), 16'($urandom), 12'd0);
				end
				2: begin
					configure($urandom, 16'($urandom), 16'($urandom), 12'($urandom_range(2048)));
				end
				3: begin
					configure(32'h0000_0000, 16'h0000, 16'hFFFF, 12'd1);
				end
				4: begin
					configure($urandom, 16'($urandom), LOCAL_PORT_RST,
						12'($urandom_range(600, 100)));
				end
				default: begin
					configure($urandom, 16'd80, 16'($urandom), BUFFER_LIMIT_RST);
				end
			endcase

			// One phase runs without any idling on either side.
			steady = (phase == 3);

			// Twice the receiver stops for a long while as the sender keeps
			// offering, so the block fills and pushes back on its input.
			if (phase == 2 || phase == 5) begin
				hold_results = 1'b1;
			end

			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// Halfway through one phase the sender pauses until every
				// result is back, then carries on with the same setting.
				if (phase == 4 && i == PHASE_ITEMS / 2) begin
					drain();
				end
				send_frame(random_frame());
			end
			drain();
		end

		steady = 1'b0;
		repeat (10) @(posedge clk);
		if (sb.mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

// File: tcp_receive_sequence_tracker.f
hw/rtl/trst_pkg.sv
hw/rtl/tcp_receive_sequence_tracker.sv
test/tcp_receive_sequence_tracker_tb.sv
